// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL files; only tbtc_emit.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define TBTC_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: always condition");

// Consequent must hold in the cycle after the antecedent.
`define TBTC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/tbtc_pkg.sv =====
package tbtc_pkg;

   localparam int BitsPerByte = 8;
   localparam int BitIdxW     = 11;
   localparam int CodeW       = 16;

   typedef enum logic [1:0] {
      PHASE_WINDOW = 2'd0,
      PHASE_LENGTH = 2'd1,
      PHASE_BITMAP = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [CodeW-1:0] type_code;
      logic             code_valid;
      logic             parse_error;
      logic             end_of_run;
   } rsp_type;

   // Work left over from one accepted byte.
   typedef struct packed {
      logic [BitsPerByte-1:0] bits;
      logic [7:0]             window;
      logic [BitIdxW-1:0]     base;
      logic                   err;
      logic                   err_only;
   } job_type;

endpackage

// ===== hw/rtl/tbtc_parse.sv =====
module tbtc_parse
   import tbtc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    accept,
   input  req_type req,
   output job_type job
);

   phase_type          phase_ff, phase_in;
   logic [7:0]         window_ff, window_in;
   logic [7:0]         left_ff, left_in;
   logic [BitIdxW-1:0] base_ff, base_in;
   logic               started_ff, started_in;

   always_comb begin
      logic [7:0] left_dec;
      logic       err;
      left_dec   = left_ff - 8'd1;
      err        = 1'b0;
      phase_in   = phase_ff;
      window_in  = window_ff;
      left_in    = left_ff;
      base_in    = base_ff;
      started_in = 1'b1;
      job.bits   = '0;
      job.window = window_ff;
      job.base   = base_ff;
      case (phase_ff)
         PHASE_LENGTH: begin
            left_in  = req.data_byte;
            base_in  = '0;
            phase_in = (req.data_byte == 8'd0) ? PHASE_WINDOW : PHASE_BITMAP;
            err      = req.final_byte && (req.data_byte != 8'd0);
         end
         PHASE_BITMAP: begin
            job.bits = req.data_byte;
            base_in  = base_ff + BitIdxW'(BitsPerByte);
            left_in  = left_dec;
            if (left_dec == 8'd0) begin
               phase_in = PHASE_WINDOW;
            end else begin
               err = req.final_byte;
            end
         end
         default: begin
            err       = req.final_byte && !started_ff;
            window_in = req.data_byte;
            phase_in  = PHASE_LENGTH;
         end
      endcase
      job.err      = err;
      job.err_only = err && (job.bits == '0);
      // End of field: back to reset state.
      if (req.final_byte) begin
         phase_in   = PHASE_WINDOW;
         window_in  = '0;
         left_in    = '0;
         base_in    = '0;
         started_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PHASE_WINDOW;
         window_ff  <= '0;
         left_ff    <= '0;
         base_ff    <= '0;
         started_ff <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         window_ff  <= window_in;
         left_ff    <= left_in;
         base_ff    <= base_in;
         started_ff <= started_in;
      end
   end

endmodule

// ===== hw/rtl/tbtc_emit.sv =====
`include "assert_macros.svh"

module tbtc_emit
   import tbtc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  job_type job,
   output logic    idle_next,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   job_type job_ff, job_in;
   logic    out_valid_ff;
   rsp_type out_ff, out_in;
   logic    active, can_emit, finishing, last_bit;
   logic    err_end_only, mid_run;
   logic [$clog2(BitsPerByte)-1:0] pos;
   logic [BitsPerByte-1:0]         rest;
   logic [BitIdxW-1:0]             idx;

   assign active   = (job_ff.bits != '0) || job_ff.err_only;
   assign can_emit = !out_valid_ff || rsp_ready;

   // Pick the most significant set bit; bit 7 is offset 0.
   always_comb begin
      pos  = '0;
      rest = job_ff.bits;
      for (int i = 0; i < BitsPerByte; i++) begin
         if (job_ff.bits[i]) begin
            pos = ($clog2(BitsPerByte))'(BitsPerByte - 1 - i);
         end
      end
      rest[($clog2(BitsPerByte))'(BitsPerByte - 1) - pos] = 1'b0;
   end

   assign last_bit  = (rest == '0);
   assign finishing = can_emit && (job_ff.err_only || last_bit);
   assign idle_next = !active || finishing;
   assign idx       = job_ff.base + BitIdxW'(pos);

   always_comb begin
      job_in = job_ff;
      out_in = out_ff;
      if (can_emit && active) begin
         if (job_ff.err_only) begin
            out_in.type_code   = '0;
            out_in.code_valid  = 1'b0;
            out_in.parse_error = 1'b1;
            out_in.end_of_run  = 1'b1;
            job_in.err_only    = 1'b0;
         end else begin
            out_in.type_code   = {job_ff.window, 8'd0} | CodeW'(idx);
            out_in.code_valid  = 1'b1;
            out_in.parse_error = job_ff.err && last_bit;
            out_in.end_of_run  = last_bit;
            job_in.bits        = rest;
         end
      end
      if (load) begin
         job_in = job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         job_ff <= job_in;
         if (can_emit) begin
            out_valid_ff <= active;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   assign err_end_only = out_ff.parse_error && out_ff.end_of_run && (out_ff.type_code == '0);
   assign mid_run      = can_emit && active && !job_ff.err_only && !last_bit;

   `TBTC_ASSERT_ALWAYS(a_err_only_no_bits, clock, reset, !job_ff.err_only || job_ff.bits == '0)
   `TBTC_ASSERT_ALWAYS(a_no_code_means_error_end, clock, reset, !out_valid_ff || out_ff.code_valid || err_end_only)
   `TBTC_ASSERT_NEXT(a_mid_run_keeps_job, clock, reset, mid_run, active)
   `TBTC_ASSERT_ALWAYS(a_no_load_while_busy, clock, reset, !load || idle_next)

endmodule

// ===== hw/rtl/type_bitmap_to_type_codes.sv =====
// Channel | Ports                                  | Payload
// request | req_valid, req_ready, req_payload      | req_type: data_byte, final_byte
// result  | rsp_valid, rsp_ready, rsp_payload      | rsp_type: type_code, code_valid,
//         |                                        |   parse_error, end_of_run
// A byte is parsed in the cycle it is accepted and held in the emitter's job
// register; its results leave from the output register, one per cycle unless stalled.
// The single code emitter sends one code per set bitmap bit; an error with no bit
// sends one error result. Bytes giving no result do not hold the emitter.
// Reset is synchronous, active high, and returns the parser to expect a window byte.
// A stalled result holds the output register; the next byte waits only while
// the emitter still has codes of the previous byte to send.
module type_bitmap_to_type_codes
   import tbtc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic    accept;
   logic    idle_next;
   job_type job;

   assign req_ready = idle_next;
   assign accept    = req_valid && req_ready;

   tbtc_parse u_parse (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_payload),
      .job    (job)
   );

   tbtc_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .load        (accept),
      .job         (job),
      .idle_next   (idle_next),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== sim/type_code_checker.sv =====
`timescale 1ns / 1ps

module type_code_checker
   import tbtc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_payload,
   output int      mismatches,
   output int      codes_owed
);

   phase_type          parse_phase = PHASE_WINDOW;
   logic [7:0]         cur_window = '0;
   logic [7:0]         bitmap_left = '0;
   logic [BitIdxW-1:0] next_bit = '0;
   logic               seen_byte = 1'b0;
   rsp_type            pending_codes[$];
   int                 fail_total = 0;
   int                 owed_total = 0;

   assign mismatches = fail_total;
   assign codes_owed = owed_total;

   task automatic report_mismatch(input string what);
      $display("ERROR %0t ns: %s", $time, what);
      fail_total++;
   endtask

   task automatic clear_parser();
      parse_phase = PHASE_WINDOW;
      cur_window  = '0;
      bitmap_left = '0;
      next_bit    = '0;
      seen_byte   = 1'b0;
   endtask

   // Work out the type codes one field byte yields and queue them.
   task automatic decode_bitmap_byte(input req_type item);
      rsp_type            found[$];
      rsp_type            res;
      logic               malformed;
      logic [BitIdxW-1:0] idx;
      int                 j;
      malformed = 1'b0;
      case (parse_phase)
         PHASE_LENGTH: begin
            bitmap_left = item.data_byte;
            next_bit    = '0;
            parse_phase = (item.data_byte == 8'd0) ? PHASE_WINDOW : PHASE_BITMAP;
            if (item.final_byte && item.data_byte != 8'd0) begin
               malformed = 1'b1;
            end
         end
         PHASE_BITMAP: begin
            for (j = 0; j < BitsPerByte; j++) begin
               if (item.data_byte[BitsPerByte-1-j]) begin
                  idx            = next_bit + BitIdxW'(j);
                  res            = '0;
                  res.type_code  = {cur_window, 8'h00} | CodeW'(idx);
                  res.code_valid = 1'b1;
                  found.push_back(res);
               end
            end
            next_bit    = next_bit + BitIdxW'(BitsPerByte);
            bitmap_left = bitmap_left - 8'd1;
            if (bitmap_left == 8'd0) begin
               parse_phase = PHASE_WINDOW;
            end else if (item.final_byte) begin
               malformed = 1'b1;
            end
         end
         default: begin
            // a final window byte is only an error when it is the whole field
            if (item.final_byte && !seen_byte) begin
               malformed = 1'b1;
            end
            cur_window  = item.data_byte;
            parse_phase = PHASE_LENGTH;
         end
      endcase
      seen_byte = 1'b1;
      if (malformed && found.size() == 0) begin
         res             = '0;
         res.parse_error = 1'b1;
         res.end_of_run  = 1'b1;
         found.push_back(res);
      end else if (found.size() > 0) begin
         res             = found.pop_back();
         res.parse_error = malformed;
         res.end_of_run  = 1'b1;
         found.push_back(res);
      end
      foreach (found[k]) begin
         pending_codes.push_back(found[k]);
      end
      if (item.final_byte) begin
         clear_parser();
      end
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (pending_codes.size() == 0) begin
         report_mismatch($sformatf("unexpected result, type_code %04h", got.type_code));
         return;
      end
      want = pending_codes.pop_front();
      if (got.type_code !== want.type_code) begin
         report_mismatch($sformatf("type_code %04h, want %04h",
                                   got.type_code, want.type_code));
      end
      if (got.code_valid !== want.code_valid) begin
         report_mismatch($sformatf("code_valid %b, want %b (type_code %04h)",
                                   got.code_valid, want.code_valid, want.type_code));
      end
      if (got.parse_error !== want.parse_error) begin
         report_mismatch($sformatf("parse_error %b, want %b (type_code %04h)",
                                   got.parse_error, want.parse_error, want.type_code));
      end
      if (got.end_of_run !== want.end_of_run) begin
         report_mismatch($sformatf("end_of_run %b, want %b (type_code %04h)",
                                   got.end_of_run, want.end_of_run, want.type_code));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_parser();
         pending_codes.delete();
      end else begin
         if (req_valid && req_ready) begin
            decode_bitmap_byte(req_payload);
         end
         if (rsp_valid && rsp_ready) begin
            check_result(rsp_payload);
         end
      end
      owed_total = pending_codes.size();
   end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top
   import tbtc_pkg::*;
();

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_kind_type;

   localparam int RandomBytes  = 90;
   localparam int HoldOffCycles = 300;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   req_type       req_payload = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   rsp_type       rsp_payload;
   int            mismatches;
   int            codes_owed;
   idle_kind_type idle_mode = IDLE_NONE;
   logic          hold_off_now = 1'b0;
   logic          hold_off_done = 1'b0;
   req_type       field_bytes[$];

   type_bitmap_to_type_codes uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   type_code_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .mismatches  (mismatches),
      .codes_owed  (codes_owed)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("type_bitmap_to_type_codes: mismatch");
      $finish;
   end

   task automatic add_byte(input logic [7:0] value, input logic fin);
      req_type item;
      item.data_byte  = value;
      item.final_byte = fin;
      field_bytes.push_back(item);
   endtask

   function automatic logic [7:0] bitmap_value();
      case ($urandom_range(3))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // Mostly well-formed fields; some cut short, some with a lone trailing byte, some noise.
   task automatic add_random_field();
      int      kind;
      int      start;
      int      windows;
      int      len;
      int      kept;
      req_type last_item;
      kind  = $urandom_range(99);
      start = field_bytes.size();
      if (kind < 10) begin
         repeat ($urandom_range(1, 5)) add_byte(8'($urandom), 1'($urandom));
         add_byte(8'($urandom), 1'b1);
         return;
      end
      windows = $urandom_range(1, 3);
      repeat (windows) begin
         len = ($urandom_range(19) == 0) ? $urandom_range(33, 40) : $urandom_range(0, 3);
         add_byte(8'($urandom), 1'b0);
         add_byte(8'(len), 1'b0);
         repeat (len) add_byte(bitmap_value(), 1'b0);
      end
      if (kind < 25) begin
         kept = $urandom_range(1, field_bytes.size() - start);
         while (field_bytes.size() > start + kept) begin
            void'(field_bytes.pop_back());
         end
      end else if (kind < 32) begin
         add_byte(8'($urandom), 1'b0);
      end
      last_item            = field_bytes.pop_back();
      last_item.final_byte = 1'b1;
      field_bytes.push_back(last_item);
   endtask

   function automatic logic sender_waits();
      return (idle_mode == IDLE_SENDER && $urandom_range(99) < 61) ||
             (idle_mode == IDLE_BOTH && $urandom_range(99) < 19);
   endfunction

   function automatic logic receiver_stalls();
      return (idle_mode == IDLE_RECEIVER && $urandom_range(99) < 61) ||
             (idle_mode == IDLE_BOTH && $urandom_range(99) < 19);
   endfunction

   initial begin
      wait (!reset);
      forever begin
         if (hold_off_now && !hold_off_done) begin
            // long hold: let the block fill and back up its input
            hold_off_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HoldOffCycles) @(posedge clock);
         end else begin
            rsp_ready <= !receiver_stalls();
            @(posedge clock);
         end
      end
   end

   initial begin
      int total;
      int directed;

      // one-byte field
      add_byte(8'h00, 1'b1);
      // lone trailing window byte after a zero-length window
      add_byte(8'h05, 1'b0);
      add_byte(8'h00, 1'b0);
      add_byte(8'h07, 1'b1);
      // full bitmap byte, well formed
      add_byte(8'h00, 1'b0);
      add_byte(8'h01, 1'b0);
      add_byte(8'hFF, 1'b1);
      // field ends on a nonzero length
      add_byte(8'hFF, 1'b0);
      add_byte(8'h03, 1'b1);
      // bitmap cut short, error on the last code
      add_byte(8'h01, 1'b0);
      add_byte(8'h02, 1'b0);
      add_byte(8'h80, 1'b1);
      // bitmap cut short on an empty byte
      add_byte(8'h02, 1'b0);
      add_byte(8'h02, 1'b0);
      add_byte(8'h00, 1'b1);
      // zero-length window as the whole field
      add_byte(8'h03, 1'b0);
      add_byte(8'h00, 1'b1);
      // two bitmap bytes, alternating bits
      add_byte(8'hFF, 1'b0);
      add_byte(8'h02, 1'b0);
      add_byte(8'h55, 1'b0);
      add_byte(8'hAA, 1'b1);
      directed = field_bytes.size();
      while (field_bytes.size() < directed + RandomBytes) begin
         add_random_field();
      end
      total = field_bytes.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < total; i++) begin
         idle_mode = idle_kind_type'((i * 4) / total);
         if (i == total / 2) begin
            hold_off_now <= 1'b1;
         end
         while (sender_waits()) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid   <= 1'b1;
         req_payload <= field_bytes[i];
         do @(posedge clock); while (!req_ready);
      end
      req_valid <= 1'b0;

      do @(posedge clock); while (codes_owed != 0);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && codes_owed == 0) begin
         $display("type_bitmap_to_type_codes: match");
      end else begin
         $display("type_bitmap_to_type_codes: mismatch");
      end
      $finish;
   end

endmodule

// ===== type_bitmap_to_type_codes.f =====
+incdir+hw/rtl
hw/rtl/tbtc_pkg.sv
hw/rtl/tbtc_parse.sv
hw/rtl/tbtc_emit.sv
hw/rtl/type_bitmap_to_type_codes.sv
sim/type_code_checker.sv
sim/tb_top.sv
